/* design/fcpr_pkg.sv */
// ----------------------------------------------------------------------------
// fcpr_pkg
// Shared types, constants and helpers of the framed command packet receiver.
// ----------------------------------------------------------------------------
package fcpr_pkg;

    localparam logic [7:0] START_FIRST  = 8'h23;  // '#'
    localparam logic [7:0] START_SECOND = 8'h25;  // '%'
    localparam int unsigned PAYLOAD_LEN = 4;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] START_SUM = START_FIRST + START_SECOND;

    localparam logic [7:0] HDR_CMD_A    = 8'h0A;
    localparam logic [7:0] HDR_CMD_B    = 8'h0B;
    localparam logic [7:0] HDR_CMD_C    = 8'h0C;
    localparam logic [7:0] HDR_PING     = 8'h0D;
    localparam logic [7:0] HDR_PWR_1    = 8'h81;
    localparam logic [7:0] HDR_PWR_2    = 8'h82;
    localparam logic [7:0] HDR_PWR_3    = 8'h83;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_SUM = 2'd1,
        ST_BAD_HDR = 2'd2
    } t_status;

    // Frame record handed from the parser to the executor.
    typedef struct packed {
        logic [7:0]                  header;
        logic [PAYLOAD_LEN-1:0][7:0] payload;
        logic                        sum_ok;
    } t_frame;

    function automatic logic header_known(input logic [7:0] hdr);
        logic known;
        unique case (hdr)
            HDR_CMD_A, HDR_CMD_B, HDR_CMD_C, HDR_PING,
            HDR_PWR_1, HDR_PWR_2, HDR_PWR_3: known = 1'b1;
            default:                         known = 1'b0;
        endcase
        return known;
    endfunction

endpackage

/* design/fcpr_in_if.sv */
// ----------------------------------------------------------------------------
// fcpr_in_if
// Byte channel into the receiver: valid/ready handshake with one rx byte.
// ----------------------------------------------------------------------------
interface fcpr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* design/fcpr_out_if.sv */
// ----------------------------------------------------------------------------
// fcpr_out_if
// Result channel: one beat per completed frame, with status and error counts.
// ----------------------------------------------------------------------------
interface fcpr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  frame_header;
    logic [7:0]  data_byte0;
    logic [7:0]  data_byte1;
    logic [7:0]  data_byte2;
    logic [7:0]  data_byte3;
    logic [1:0]  frame_status;
    logic [15:0] checksum_errors;
    logic [15:0] unknown_headers;

    modport source (
        output valid, input ready,
        output frame_header, output data_byte0, output data_byte1,
        output data_byte2, output data_byte3, output frame_status,
        output checksum_errors, output unknown_headers
    );
    modport sink (
        input valid, output ready,
        input frame_header, input data_byte0, input data_byte1,
        input data_byte2, input data_byte3, input frame_status,
        input checksum_errors, input unknown_headers
    );
endinterface

/* design/fcpr_front.sv */
// ----------------------------------------------------------------------------
// fcpr_front
// Frame parser: tracks start marks, collects header and payload, checks sum.
// ----------------------------------------------------------------------------
module fcpr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    output logic            o_ready,
    output logic            o_push,
    output fcpr_pkg::t_frame o_frame,
    input  logic            i_push_ready
);

    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2,
        PH_CHECK  = 2'd3
    } t_phase;

    localparam int unsigned IDX_W = $clog2(fcpr_pkg::PAYLOAD_LEN);

    t_phase                              r_phase, n_phase;
    logic [7:0]                          r_last;
    logic [7:0]                          r_sum, n_sum;
    logic [IDX_W-1:0]                    r_idx, n_idx;
    logic [7:0]                          r_hdr;
    logic [fcpr_pkg::PAYLOAD_LEN-1:0][7:0] r_pay;

    logic accept;
    logic start_mark;

    // Only the checksum byte needs room in the queue.
    assign o_ready    = i_push_ready || (r_phase != PH_CHECK);
    assign accept     = i_valid && o_ready;
    assign start_mark = (r_last == fcpr_pkg::START_FIRST) &&
                        (i_byte == fcpr_pkg::START_SECOND);
    assign o_push     = accept && !start_mark && (r_phase == PH_CHECK);

    assign o_frame.header  = r_hdr;
    assign o_frame.payload = r_pay;
    assign o_frame.sum_ok  = (r_sum == i_byte);

    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_idx   = r_idx;
        if (start_mark) begin
            n_phase = PH_HEADER;
            n_sum   = fcpr_pkg::START_SUM;
        end else begin
            unique case (r_phase)
                PH_WAIT: begin
                end
                PH_HEADER: begin
                    n_sum   = r_sum + i_byte;
                    n_idx   = '0;
                    n_phase = PH_DATA;
                end
                PH_DATA: begin
                    n_sum = r_sum + i_byte;
                    n_idx = r_idx + IDX_W'(1);
                    if (r_idx == IDX_W'(fcpr_pkg::PAYLOAD_LEN - 1)) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_phase = PH_WAIT;
                end
                default: begin
                    n_phase = PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_last  <= '0;
            r_sum   <= '0;
            r_idx   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_last  <= i_byte;
            r_sum   <= n_sum;
            r_idx   <= n_idx;
        end
    end

    // Payload stores need no reset: every frame writes them before the check.
    always_ff @(posedge i_clk) begin
        if (accept && !start_mark) begin
            if (r_phase == PH_HEADER) begin
                r_hdr <= i_byte;
            end
            if (r_phase == PH_DATA) begin
                r_pay[r_idx] <= i_byte;
            end
        end
    end

endmodule

/* design/fcpr_queue.sv */
// ----------------------------------------------------------------------------
// fcpr_queue
// Short frame queue decoupling the parser from the executor.
// ----------------------------------------------------------------------------
module fcpr_queue #(
    parameter int unsigned P_DEPTH = fcpr_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fcpr_pkg::t_frame i_frame,
    output logic             o_push_ready,
    output logic             o_valid,
    output fcpr_pkg::t_frame o_frame,
    input  logic             i_pop
);

    localparam int unsigned PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(P_DEPTH + 1);

    fcpr_pkg::t_frame r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_push_ready = (r_cnt != CNT_W'(P_DEPTH));
    assign o_valid      = (r_cnt != '0);
    assign o_frame      = r_mem[r_rptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(P_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= ptr_next(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= ptr_next(r_rptr);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_frame;
        end
    end

endmodule

/* design/fcpr_back.sv */
// ----------------------------------------------------------------------------
// fcpr_back
// Frame executor: grades each frame, advances error counts, drives results.
// ----------------------------------------------------------------------------
module fcpr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  fcpr_pkg::t_frame i_frame,
    output logic             o_pop,
    fcpr_out_if.source       o_res
);

    logic                        r_valid;
    logic [7:0]                  r_hdr;
    logic [fcpr_pkg::PAYLOAD_LEN-1:0][7:0] r_pay;
    fcpr_pkg::t_status           r_status, n_status;
    logic [15:0]                 r_bad_sum, n_bad_sum;
    logic [15:0]                 r_bad_hdr, n_bad_hdr;

    assign o_pop = i_valid && (!r_valid || o_res.ready);

    always_comb begin
        n_bad_sum = r_bad_sum;
        n_bad_hdr = r_bad_hdr;
        if (!i_frame.sum_ok) begin
            n_status  = fcpr_pkg::ST_BAD_SUM;
            n_bad_sum = r_bad_sum + 16'd1;
        end else if (fcpr_pkg::header_known(i_frame.header)) begin
            n_status  = fcpr_pkg::ST_OK;
        end else begin
            n_status  = fcpr_pkg::ST_BAD_HDR;
            n_bad_hdr = r_bad_hdr + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_bad_sum <= '0;
            r_bad_hdr <= '0;
        end else if (o_pop) begin
            r_valid   <= 1'b1;
            r_bad_sum <= n_bad_sum;
            r_bad_hdr <= n_bad_hdr;
        end else if (o_res.ready) begin
            r_valid   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hdr    <= i_frame.header;
            r_pay    <= i_frame.payload;
            r_status <= n_status;
        end
    end

    assign o_res.valid           = r_valid;
    assign o_res.frame_header    = r_hdr;
    assign o_res.data_byte0      = r_pay[0];
    assign o_res.data_byte1      = r_pay[1];
    assign o_res.data_byte2      = r_pay[2];
    assign o_res.data_byte3      = r_pay[3];
    assign o_res.frame_status    = r_status;
    assign o_res.checksum_errors = r_bad_sum;
    assign o_res.unknown_headers = r_bad_hdr;

endmodule

/* design/framed_command_packet_receiver_unit.sv */
// ----------------------------------------------------------------------------
// framed_command_packet_receiver_unit
// Serial command deframer with additive checksum and error counters.
// ----------------------------------------------------------------------------
//
//   Port     Dir  Beat                               Handshake
//   i_rx     in   one received byte (rx_byte)        valid/ready
//   o_res    out  header, 4 data bytes, status,      valid/ready
//                 checksum and header error counts
//
// Flow: one byte per cycle while the frame queue has room for checksum
//   bytes; a result beat is registered: its checksum byte is written into
//   the queue, then the back end loads the record into the output register.
// Reset: synchronous active low; phase, previous byte, sum, counters, queue
//   pointers and the output valid clear.
// Stalls: only a checksum byte waits on a full frame queue; header and data
//   bytes keep flowing while results back up at o_res.
//
// The front parses the byte stream: a '#' followed by '%' restarts a frame
// in any phase, then it collects the header and four data bytes, keeping a
// running modulo-256 sum that includes the start mark. On the checksum byte
// it pushes a frame record with a sum-match flag into the queue. The back
// end pops records, grades them (bad sum first, then unknown header), bumps
// the wrapping error counts and holds the result in an output register.
// ----------------------------------------------------------------------------
module framed_command_packet_receiver_unit #(
    parameter int unsigned P_QUEUE_DEPTH = fcpr_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fcpr_in_if.sink    i_rx,
    fcpr_out_if.source o_res
);

    // Parser to queue
    logic             front_push;
    logic             queue_push_ready;
    fcpr_pkg::t_frame front_frame;

    // Queue to executor
    logic             queue_valid;
    logic             back_pop;
    fcpr_pkg::t_frame queue_frame;

    fcpr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_rx.valid),
        .i_byte       (i_rx.rx_byte),
        .o_ready      (i_rx.ready),
        .o_push       (front_push),
        .o_frame      (front_frame),
        .i_push_ready (queue_push_ready)
    );

    fcpr_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_push),
        .i_frame      (front_frame),
        .o_push_ready (queue_push_ready),
        .o_valid      (queue_valid),
        .o_frame      (queue_frame),
        .i_pop        (back_pop)
    );

    // Hold results here until the sink takes them; drop nothing.
    fcpr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_frame (queue_frame),
        .o_pop   (back_pop),
        .o_res   (o_res)
    );

endmodule

/* design/fcpr_checker.sv */
// ----------------------------------------------------------------------------
// fcpr_checker
// Port-level checks of the receiver, bound to the top level.
// ----------------------------------------------------------------------------
module fcpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_out_header,
    input logic [1:0]  i_out_status,
    input logic [15:0] i_out_sum_errs
);

    logic hdr_known;
    assign hdr_known = fcpr_pkg::header_known(i_out_header);

    // A stalled result stays up with its error count unchanged.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_sum_errs))
        else $error("result valid or count changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status != 2'd3))
        else $error("illegal frame status");

    a_ok_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == fcpr_pkg::ST_OK) |-> hdr_known)
        else $error("accepted frame with unknown header");

    a_unknown_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == fcpr_pkg::ST_BAD_HDR) |-> !hdr_known)
        else $error("known header graded as unknown");

endmodule

bind framed_command_packet_receiver_unit fcpr_checker u_fcpr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_header   (o_res.frame_header),
    .i_out_status   (o_res.frame_status),
    .i_out_sum_errs (o_res.checksum_errors)
);

/* dv/framed_command_packet_receiver_unit_test.sv */
// ----------------------------------------------------------------------------
// framed_command_packet_receiver_unit_test
// Self-checking bench for the serial command deframer. Clocked driver and
// monitor processes exercise the byte and result channels. Stimulus is a
// short directed frame set, then random frames, broken frames and noise,
// run under four idling phases. One phase includes a long result hold-off.
// A behavioral deframer predicts every result beat.
// ----------------------------------------------------------------------------
module framed_command_packet_receiver_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PHASE_BYTES    = 270;   // random bytes per phase
    localparam int unsigned HOLD_CYCLES    = 500;   // long result hold-off
    localparam int unsigned WATCHDOG_LIMIT = 5000;  // cycles with no beat
    localparam int unsigned DRAIN_CYCLES   = 8;     // idle wait after the queues drain

    // Phase order: no idling, sender idle, receiver stall, both.
    localparam int unsigned SRC_IDLE_PCT [4] = '{0, 86, 0, 21};
    localparam int unsigned SNK_STALL_PCT[4] = '{0, 0, 86, 21};

    localparam logic [7:0] KNOWN_HDRS[7] = '{
        fcpr_pkg::HDR_CMD_A, fcpr_pkg::HDR_CMD_B, fcpr_pkg::HDR_CMD_C,
        fcpr_pkg::HDR_PING, fcpr_pkg::HDR_PWR_1, fcpr_pkg::HDR_PWR_2,
        fcpr_pkg::HDR_PWR_3
    };

    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2,
        PH_CHECK  = 2'd3
    } t_parse_phase;

    typedef struct packed {
        logic [7:0]        header;
        logic [3:0][7:0]   data;
        fcpr_pkg::t_status status;
        logic [15:0]       sum_errs;
        logic [15:0]       hdr_errs;
    } t_frame_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fcpr_in_if  rx_if ();
    fcpr_out_if res_if ();

    framed_command_packet_receiver_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    logic [7:0]    rx_pending_q[$];    // bytes waiting for the driver
    t_frame_result frames_due_q[$];    // predicted result beats, oldest first
    int unsigned   bytes_queued = 0;
    int unsigned   bytes_taken  = 0;
    int unsigned   fail_count   = 0;
    int unsigned   src_idle_pct   = 0;
    int unsigned   sink_stall_pct = 0;
    bit            hold_pending   = 1'b0;
    bit            hold_done      = 1'b0;
    int unsigned   hold_left      = 0;
    int unsigned   quiet_cycles   = 0;

    // Deframer shadow state
    logic [7:0]      last_rx    = 8'h00;
    t_parse_phase    parse_ph   = PH_WAIT;
    logic [7:0]      cur_hdr    = 8'h00;
    logic [3:0][7:0] cur_data   = '0;
    logic [2:0]      data_idx   = 3'd0;
    logic [7:0]      run_sum    = 8'h00;
    logic [15:0]     bad_sum_n  = 16'h0000;
    logic [15:0]     bad_hdr_n  = 16'h0000;

    function automatic bit is_known_header(input logic [7:0] hdr);
        bit known;
        known = 1'b0;
        foreach (KNOWN_HDRS[k]) begin
            if (KNOWN_HDRS[k] == hdr) known = 1'b1;
        end
        return known;
    endfunction

    // Advance the shadow deframer by one accepted byte; queue a result on
    // the checksum byte.
    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0]    prev;
        t_frame_result res;
        prev    = last_rx;
        last_rx = b;
        // A start mark restarts the frame from any phase and yields nothing.
        if (prev == fcpr_pkg::START_FIRST && b == fcpr_pkg::START_SECOND) begin
            parse_ph = PH_HEADER;
            run_sum  = fcpr_pkg::START_SUM;
        end else begin
            case (parse_ph)
                PH_WAIT: ;
                PH_HEADER: begin
                    cur_hdr  = b;
                    run_sum  = run_sum + b;
                    data_idx = 3'd0;
                    parse_ph = PH_DATA;
                end
                PH_DATA: begin
                    cur_data[data_idx[1:0]] = b;
                    run_sum  = run_sum + b;
                    data_idx = data_idx + 3'd1;
                    if (data_idx >= fcpr_pkg::PAYLOAD_LEN) parse_ph = PH_CHECK;
                end
                PH_CHECK: begin
                    // Bad sum wins over an unknown header.
                    if (run_sum != b) begin
                        bad_sum_n  = bad_sum_n + 16'd1;
                        res.status = fcpr_pkg::ST_BAD_SUM;
                    end else if (!is_known_header(cur_hdr)) begin
                        bad_hdr_n  = bad_hdr_n + 16'd1;
                        res.status = fcpr_pkg::ST_BAD_HDR;
                    end else begin
                        res.status = fcpr_pkg::ST_OK;
                    end
                    res.header   = cur_hdr;
                    res.data     = cur_data;
                    res.sum_errs = bad_sum_n;
                    res.hdr_errs = bad_hdr_n;
                    frames_due_q.push_back(res);
                    parse_ph = PH_WAIT;
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b);
        rx_pending_q.push_back(b);
        bytes_queued++;
    endtask

    // Queue a full frame: start mark, header, payload, checksum. A bad
    // checksum is offset by a nonzero amount so it never matches.
    task automatic queue_frame(input logic [7:0] hdr, input logic [3:0][7:0] data,
                               input bit good_sum);
        logic [7:0] sum;
        sum = fcpr_pkg::START_SUM + hdr;
        queue_byte(fcpr_pkg::START_FIRST);
        queue_byte(fcpr_pkg::START_SECOND);
        queue_byte(hdr);
        for (int k = 0; k < 4; k++) begin
            queue_byte(data[k]);
            sum = sum + data[k];
        end
        if (!good_sum) sum = sum + 8'($urandom_range(1, 255));
        queue_byte(sum);
    endtask

    // Mostly well-formed frames with random content; the rest are
    // truncated frames and line noise.
    task automatic queue_random_chunk();
        int unsigned     pick;
        int unsigned     n;
        logic [7:0]      hdr;
        logic [3:0][7:0] data;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            if ($urandom_range(0, 99) < 60) hdr = KNOWN_HDRS[$urandom_range(0, 6)];
            else                            hdr = 8'($urandom());
            data = 32'($urandom());
            queue_frame(hdr, data, $urandom_range(0, 99) < 75);
        end else if (pick < 87) begin
            queue_byte(fcpr_pkg::START_FIRST);
            queue_byte(fcpr_pkg::START_SECOND);
            n = $urandom_range(0, 5);
            repeat (n) queue_byte(8'($urandom()));
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                if ($urandom_range(0, 3) == 0) queue_byte(fcpr_pkg::START_FIRST);
                else                           queue_byte(8'($urandom()));
            end
        end
    endtask

    task automatic wait_drained();
        while (bytes_taken != bytes_queued || frames_due_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Byte driver: hold the beat while stalled, otherwise pull the next byte
    // unless the sender idles this cycle. Predict on every accepted beat.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : byte_driver
        bit stalled;
        if (!i_rst_n) begin
            rx_if.valid   <= 1'b0;
            rx_if.rx_byte <= 8'h00;
        end else begin
            stalled = rx_if.valid && !rx_if.ready;
            if (rx_if.valid && rx_if.ready) begin
                deframe_byte(rx_if.rx_byte);
                bytes_taken++;
            end
            if (!stalled) begin
                if (rx_pending_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    rx_if.valid   <= 1'b1;
                    rx_if.rx_byte <= rx_pending_q.pop_front();
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare each result beat with the oldest prediction,
    // and drive ready with random stalls plus one long hold-off.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_frame_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (frames_due_q.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual header %h",
                             $time, res_if.frame_header);
                    fail_count++;
                end else begin
                    want = frames_due_q.pop_front();
                    check_field("frame_header", 16'(want.header), 16'(res_if.frame_header));
                    check_field("data_byte0", 16'(want.data[0]), 16'(res_if.data_byte0));
                    check_field("data_byte1", 16'(want.data[1]), 16'(res_if.data_byte1));
                    check_field("data_byte2", 16'(want.data[2]), 16'(res_if.data_byte2));
                    check_field("data_byte3", 16'(want.data[3]), 16'(res_if.data_byte3));
                    check_field("frame_status", 16'(want.status), 16'(res_if.frame_status));
                    check_field("checksum_errors", want.sum_errs, res_if.checksum_errors);
                    check_field("unknown_headers", want.hdr_errs, res_if.unknown_headers);
                end
            end
            if (hold_pending && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // Drop the run when neither channel moves a beat for too long.
    always @(posedge i_clk) begin : watchdog
        if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: watchdog timeout, %0d results outstanding",
                     $time, frames_due_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset, directed frames, then the random phases
    // ------------------------------------------------------------------------
    initial begin : sequencer
        int unsigned target;
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        res_if.ready  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < 4; p++) begin
            src_idle_pct   = SRC_IDLE_PCT[p];
            sink_stall_pct = SNK_STALL_PCT[p];
            if (p == 0) begin
                // Noise while waiting for a start mark.
                queue_byte(8'hFF);
                // Known header, payload extremes, good sum.
                queue_frame(fcpr_pkg::HDR_CMD_A, {8'hFF, 8'h00, 8'hFF, 8'h00}, 1'b1);
                // Unknown header with good sum.
                queue_frame(8'hFF, {8'h80, 8'h01, 8'h5A, 8'hA5}, 1'b1);
                // Start mark inside a frame: restart after header and one
                // data byte, then the ping header with a bad sum.
                queue_byte(fcpr_pkg::START_FIRST);
                queue_byte(fcpr_pkg::START_SECOND);
                queue_byte(fcpr_pkg::HDR_PWR_3);
                queue_byte(8'h11);
                queue_frame(fcpr_pkg::HDR_PING, {8'h78, 8'h56, 8'h34, 8'h12}, 1'b0);
                // Header zero with good sum.
                queue_frame(8'h00, {8'h00, 8'h00, 8'h00, 8'h00}, 1'b1);
                // Starve the result side while bytes keep coming.
                hold_pending = 1'b1;
            end
            target = bytes_queued + PHASE_BYTES;
            while (bytes_queued < target) queue_random_chunk();
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
